>>> src/uart_dual_ring_buffer_core_macros.svh
// Assertion macros shared by the UART dual ring buffer core.
// Depends on a clock named clk and an active high reset named rst in the user scope.
`ifndef UART_DUAL_RING_BUFFER_CORE_MACROS_SVH
`define UART_DUAL_RING_BUFFER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UDRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/udrb_pkg.sv
// Package for the UART dual ring buffer core: command codes, word structs
// and queue control structs. No dependencies.
`timescale 1ns / 1ps

package udrb_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int LEVEL_W   = 7;
  localparam int BYTE_W    = 8;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_IRQ  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data;
    logic              tx_idle;
    logic              rx_event;
    logic              tx_event;
  } req_t;

  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic [BYTE_W-1:0]  read_byte;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               dropped;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

endpackage

>>> src/udrb_fifo.sv
// One byte ring queue: a synchronous memory with a registered read port,
// wrapping pointers and a fill count. Depends on udrb_pkg.
`timescale 1ns / 1ps

module udrb_fifo #(
  parameter int QUEUE_DEPTH = udrb_pkg::DEPTH_DEF,
  parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  udrb_pkg::fifo_ctl_t        ctl,
  input  logic [udrb_pkg::BYTE_W-1:0] wr_data,
  output logic [udrb_pkg::BYTE_W-1:0] rd_data,
  output udrb_pkg::fifo_sts_t        sts,
  output logic [FILL_W-1:0]          fill
);
  import udrb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_pos;
  logic [PTR_W-1:0]  rd_pos;
  logic [PTR_W-1:0]  wr_pos_next;
  logic [PTR_W-1:0]  rd_pos_next;
  logic [FILL_W-1:0] fill_next;

  assign sts.full  = (fill == FILL_W'(QUEUE_DEPTH));
  assign sts.empty = (fill == '0);

  always_comb begin
    wr_pos_next = (wr_pos == PTR_LAST) ? '0 : wr_pos + PTR_W'(1);
    rd_pos_next = (rd_pos == PTR_LAST) ? '0 : rd_pos + PTR_W'(1);
    fill_next   = fill;
    if (ctl.push && !ctl.pop) begin
      fill_next = fill + FILL_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  // The caller never pushes into a full queue or pops an empty one.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      rd_pos <= '0;
      fill   <= '0;
    end else begin
      if (ctl.push) begin
        wr_pos <= wr_pos_next;
      end
      if (ctl.pop) begin
        rd_pos <= rd_pos_next;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_pos] <= wr_data;
    end
    if (ctl.pop) begin
      rd_data <= mem[rd_pos];
    end
  end

endmodule

>>> src/uart_dual_ring_buffer_core.sv
// Top level of the UART dual ring buffer core: command decode, result word
// assembly and two udrb_fifo queues. Depends on udrb_pkg and the macros header.
//
// Usage:
//   A command word (req) is taken at a rising edge where start is high and busy
//   is low. Commands are put (send a byte or queue it for transmit), get (pop a
//   received byte) and interrupt (push a received byte, pop a transmit byte).
//   Exactly one result word (rsp) follows for each command, shown on rsp for one
//   cycle while done is high. The receiver cannot stall; it must take the word
//   in that cycle.
// Timing:
//   The result word passes through the registered read of the queue memories
//   and then through the result register. busy is high for the cycle after
//   acceptance, so a new command is not taken until the memory read of the
//   pop for the last one has landed. A start during the done cycle is accepted.
// Reset:
//   rst is synchronous and active high. It empties both queues by clearing
//   their pointers and fill counts; the memories themselves are not cleared.
//   No result is pending after reset.
`timescale 1ns / 1ps
`include "uart_dual_ring_buffer_core_macros.svh"

module uart_dual_ring_buffer_core #(
  parameter int QUEUE_DEPTH = udrb_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  udrb_pkg::req_t req,
  output logic           done,
  output udrb_pkg::rsp_t rsp
);
  import udrb_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  fifo_ctl_t         rx_ctl;
  fifo_ctl_t         tx_ctl;
  fifo_sts_t         rx_sts;
  fifo_sts_t         tx_sts;
  logic [BYTE_W-1:0] rx_rd_data;
  logic [BYTE_W-1:0] tx_rd_data;
  logic [FILL_W-1:0] rx_fill;
  logic [FILL_W-1:0] tx_fill;

  // Decoded outcome of the accepted command, held while the pop read lands.
  logic              pending;
  logic              tx_direct;
  logic              rx_popped;
  logic              tx_popped;
  logic              drop;
  logic [BYTE_W-1:0] direct_byte;
  logic              tx_direct_next;
  logic              drop_next;
  rsp_t              rsp_next;

  assign busy   = pending;
  assign accept = start && !pending;

  always_comb begin
    rx_ctl         = '0;
    tx_ctl         = '0;
    tx_direct_next = 1'b0;
    drop_next      = 1'b0;
    if (accept) begin
      case (req.cmd)
        CMD_PUT: begin
          if (req.tx_idle) begin
            tx_direct_next = 1'b1;
          end else if (tx_sts.full) begin
            drop_next = 1'b1;
          end else begin
            tx_ctl.push = 1'b1;
          end
        end
        CMD_GET: begin
          rx_ctl.pop = !rx_sts.empty;
        end
        CMD_IRQ: begin
          if (req.rx_event) begin
            rx_ctl.push = !rx_sts.full;
            drop_next   = rx_sts.full;
          end
          tx_ctl.pop = req.tx_event && !tx_sts.empty;
        end
        default: begin
        end
      endcase
    end
  end

  udrb_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FILL_W     (FILL_W)
  ) u_rx_fifo (
    .clk    (clk),
    .rst    (rst),
    .ctl    (rx_ctl),
    .wr_data(req.data),
    .rd_data(rx_rd_data),
    .sts    (rx_sts),
    .fill   (rx_fill)
  );

  udrb_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FILL_W     (FILL_W)
  ) u_tx_fifo (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tx_ctl),
    .wr_data(req.data),
    .rd_data(tx_rd_data),
    .sts    (tx_sts),
    .fill   (tx_fill)
  );

  always_comb begin
    rsp_next           = '0;
    rsp_next.tx_valid  = tx_direct || tx_popped;
    if (tx_direct) begin
      rsp_next.tx_byte = direct_byte;
    end else if (tx_popped) begin
      rsp_next.tx_byte = tx_rd_data;
    end
    if (rx_popped) begin
      rsp_next.read_byte = rx_rd_data;
    end
    rsp_next.rx_level = LEVEL_W'(rx_fill);
    rsp_next.tx_level = LEVEL_W'(tx_fill);
    rsp_next.dropped  = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      done      <= 1'b0;
      tx_direct <= 1'b0;
      rx_popped <= 1'b0;
      tx_popped <= 1'b0;
      drop      <= 1'b0;
    end else begin
      pending   <= accept;
      done      <= pending;
      tx_direct <= tx_direct_next;
      rx_popped <= rx_ctl.pop;
      tx_popped <= tx_ctl.pop;
      drop      <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      direct_byte <= req.data;
    end
    if (pending) begin
      rsp <= rsp_next;
    end
  end

  `UDRB_ASSERT_NEXT(a_result_follows, pending, done, "result word missing after command")
  `UDRB_ASSERT_NEXT(a_single_result, done, !done, "result word shown for more than one cycle")
  `UDRB_ASSERT_NOW(a_fill_bound, 1'b1, (rx_fill <= FILL_W'(QUEUE_DEPTH)) && (tx_fill <= FILL_W'(QUEUE_DEPTH)), "queue fill count above depth")
  `UDRB_ASSERT_NOW(a_tx_byte_idle, done && !rsp.tx_valid, rsp.tx_byte == '0, "transmit byte set without a transmit")

endmodule
